@@ rtl/prarq_pkg.sv @@
// Shared types and constants for the partial-reliability ARQ sender.
// Used by prarq_history and partial_reliability_arq_sender; depends on nothing.
`default_nettype none

package prarq_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W       = 2;
    localparam int ACTION_W    = 3;
    localparam int TARGET_W    = 10;
    localparam int RETRY_W     = 8;
    localparam int COUNT_W     = 10;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;

    // Reliability is held in thousandths
    localparam int RELIABILITY_SCALE = 1000;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    // Result actions
    localparam logic [ACTION_W-1:0] ACT_IGNORED    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TX_NEW     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RETRANSMIT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_HANDSHAKE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELIVERED  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DROPPED    = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_RELIABILITY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RETRIES        = 1'd1;

    // Register reset values
    localparam logic [TARGET_W-1:0] TARGET_RESET      = 10'd500;
    localparam logic [RETRY_W-1:0]  MAX_RETRIES_RESET = 8'd10;
    localparam logic [RETRY_W-1:0]  RETRY_SATURATE    = 8'd255;

    // Request from the sender control to the outcome history
    typedef struct packed {
        logic clear;
        logic record;
        logic outcome;
    } hist_cmd_t;

endpackage

`default_nettype wire

@@ rtl/prarq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module prarq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/prarq_history.sv @@
// Sliding outcome history with running fill and success counts and the
// retransmit decision. Depends on prarq_pkg and prarq_ram.
`default_nettype none

module prarq_history #(
    parameter int HISTORY_DEPTH = 512,
    localparam int AW = $clog2(HISTORY_DEPTH),
    localparam int FW = $clog2(HISTORY_DEPTH + 1)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire prarq_pkg::hist_cmd_t            cmd,
    input  wire logic [prarq_pkg::TARGET_W-1:0]  target,
    output logic                                 resend_ok,
    output logic      [FW-1:0]                   fill_next,
    output logic      [FW-1:0]                   succ_next
);

    localparam int PW = FW + prarq_pkg::TARGET_W + 1;

    logic [AW-1:0] oldest_reg, oldest_next;
    logic [FW-1:0] fill_reg, succ_reg;
    logic          byp_hit_reg, byp_bit_reg;
    logic          ram_q, rd_bit;
    logic          full;
    logic [FW:0]   slot_sum, slot_wrap;
    logic [AW:0]   oldest_inc;
    logic [AW-1:0] oldest_adv;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic [PW-1:0] scaled_succ, target_fill, upper_fill;

    assign full = (fill_reg == FW'(HISTORY_DEPTH));

    // Slot after the newest entry, wrapped into the ring
    assign slot_sum  = (FW + 1)'(oldest_reg) + (FW + 1)'(fill_reg);
    assign slot_wrap = (slot_sum >= (FW + 1)'(HISTORY_DEPTH))
                     ? slot_sum - (FW + 1)'(HISTORY_DEPTH) : slot_sum;

    // Oldest pointer advanced by one with wrap
    assign oldest_inc = (AW + 1)'(oldest_reg) + (AW + 1)'(1);
    assign oldest_adv = (oldest_inc == (AW + 1)'(HISTORY_DEPTH))
                      ? '0 : oldest_inc[AW-1:0];

    // The RAM read always follows the oldest entry; a write to that same
    // entry in the read cycle is forwarded.
    assign rd_bit = byp_hit_reg ? byp_bit_reg : ram_q;

    // Counter and pointer updates for a record or clear request
    always_comb begin
        fill_next   = fill_reg;
        succ_next   = succ_reg;
        oldest_next = oldest_reg;
        wr_en       = 1'b0;
        wr_addr     = slot_wrap[AW-1:0];
        wr_data     = cmd.outcome;
        if (cmd.clear) begin
            fill_next   = '0;
            succ_next   = '0;
            oldest_next = '0;
        end else if (cmd.record) begin
            wr_en = 1'b1;
            if (!full) begin
                fill_next = fill_reg + FW'(1);
                succ_next = succ_reg + FW'(cmd.outcome);
            end else begin
                wr_addr     = oldest_reg;
                succ_next   = succ_reg - FW'(rd_bit) + FW'(cmd.outcome);
                oldest_next = oldest_adv;
            end
        end
    end

    // Exact reliability compare against target and target plus one thousandth
    assign scaled_succ = PW'(succ_reg) * PW'(prarq_pkg::RELIABILITY_SCALE);
    assign target_fill = PW'(target) * PW'(fill_reg);
    assign upper_fill  = target_fill + PW'(fill_reg);

    always_comb begin
        if (fill_reg == '0) begin
            resend_ok = (target != '0);
        end else begin
            resend_ok = (scaled_succ < upper_fill) && (scaled_succ != target_fill);
        end
    end

    // History state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg  <= '0;
            fill_reg    <= '0;
            succ_reg    <= '0;
            byp_hit_reg <= 1'b0;
        end else begin
            oldest_reg  <= oldest_next;
            fill_reg    <= fill_next;
            succ_reg    <= succ_next;
            byp_hit_reg <= wr_en && (wr_addr == oldest_next);
        end
    end

    always_ff @(posedge aclk) begin
        byp_bit_reg <= wr_data;
    end

    prarq_ram #(
        .WIDTH (1),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (oldest_next),
        .rd_data (ram_q)
    );

endmodule

`default_nettype wire

@@ rtl/partial_reliability_arq_sender.sv @@
// Stop-and-wait ARQ sender with alternating sequence bit and partial reliability.
// Depends on prarq_pkg and prarq_history (which holds the prarq_ram history).
//
// Usage:
// Events enter on the s_ stream: s_tuser carries the command (send, ack,
// timeout), s_tdata the arriving header bits. Every accepted event gives
// exactly one result transaction on the m_ stream: m_tuser carries the action,
// m_tdata the sequence bit, give-up flag, retry count and history counts.
// Target reliability and retry limit are written through the cfg_ port, which
// is always ready; write it only while the block is idle.
// An accepted event passes through the input register and the result register
// to m_tvalid. Throughput is one event per cycle while m_tready stays high,
// limited by the single pass through the control logic, the history counters
// and the one target-by-fill multiply in the retransmit decision.
// An input register and a result register part the two sides; when m_tready
// is low both hold their transaction and s_tready falls once both are full.
// Reset (aresetn low, synchronous) empties both registers, returns the sender
// to idle with sequence bit zero, empties the history and restores the
// registers to 500 and 10. The history store is tracked by its fill count, so
// no clearing pass follows reset.
`default_nettype none

module partial_reliability_arq_sender #(
    parameter int HISTORY_DEPTH = 512
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Event stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [prarq_pkg::S_TDATA_W-1:0]     s_tdata,  // ack_flag, syn_flag, ack_number
    input  wire logic [prarq_pkg::CMD_W-1:0]         s_tuser,  // command
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [prarq_pkg::M_TDATA_W-1:0]     m_tdata,  // sequence_bit, gave_up,
                                                               // retries_used, success_count,
                                                               // filled_count
    output logic      [prarq_pkg::ACTION_W-1:0]      m_tuser,  // action
    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [prarq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [prarq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW = prarq_pkg::COUNT_W;

    // Input register
    logic                            in_valid_reg;
    logic [prarq_pkg::CMD_W-1:0]     in_cmd_reg;
    logic                            in_ack_reg, in_syn_reg, in_num_reg;

    // Sender state and configuration
    logic                            next_seq_reg, next_seq_next;
    logic                            awaiting_reg, awaiting_next;
    logic [prarq_pkg::RETRY_W-1:0]   retry_reg, retry_next, retry_inc;
    logic [prarq_pkg::TARGET_W-1:0]  target_reg;
    logic [prarq_pkg::RETRY_W-1:0]   max_retries_reg;

    // Result register
    logic                            out_valid_reg;
    logic [prarq_pkg::ACTION_W-1:0]  out_action_reg, action_next;
    logic                            out_seq_reg, seq_next;
    logic                            out_gave_reg, gave_next;
    logic [prarq_pkg::RETRY_W-1:0]   out_retries_reg;
    logic [CW-1:0]                   out_succ_reg, out_fill_reg;

    logic                            move;
    logic                            retransmit;
    logic                            outstanding;
    prarq_pkg::hist_cmd_t            hist_cmd;
    logic                            hist_resend_ok;
    logic [FW-1:0]                   hist_fill_next, hist_succ_next;
    logic [FW+CW-1:0]                fill_ext, succ_ext;

    // Handshakes: an event moves on when the result register is free or drains
    assign move      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || move;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = {2'b00, out_fill_reg, out_succ_reg, out_retries_reg,
                       out_gave_reg, out_seq_reg};

    assign outstanding = ~next_seq_reg;
    assign retry_inc   = (retry_reg == prarq_pkg::RETRY_SATURATE)
                       ? retry_reg : retry_reg + 8'd1;

    // Event decode and state update
    always_comb begin
        next_seq_next    = next_seq_reg;
        awaiting_next    = awaiting_reg;
        retry_next       = retry_reg;
        action_next      = prarq_pkg::ACT_IGNORED;
        seq_next         = 1'b0;
        gave_next        = 1'b0;
        retransmit       = 1'b0;
        hist_cmd         = '0;
        case (in_cmd_reg)
            prarq_pkg::CMD_SEND: begin
                seq_next      = next_seq_reg;
                next_seq_next = ~next_seq_reg;
                awaiting_next = 1'b1;
                retry_next    = '0;
                action_next   = prarq_pkg::ACT_TX_NEW;
            end
            prarq_pkg::CMD_ACK: begin
                if (awaiting_reg) begin
                    if (in_syn_reg && in_ack_reg) begin
                        action_next    = prarq_pkg::ACT_HANDSHAKE;
                        next_seq_next  = ~next_seq_reg;
                        awaiting_next  = 1'b0;
                        hist_cmd.clear = 1'b1;
                    end else if (in_ack_reg && (in_num_reg == next_seq_reg)) begin
                        action_next      = prarq_pkg::ACT_DELIVERED;
                        seq_next         = outstanding;
                        hist_cmd.record  = 1'b1;
                        hist_cmd.outcome = 1'b1;
                        awaiting_next    = 1'b0;
                    end else begin
                        retransmit = 1'b1;
                    end
                end
            end
            prarq_pkg::CMD_TIMEOUT: begin
                if (awaiting_reg) begin
                    if (hist_resend_ok) begin
                        retransmit = 1'b1;
                    end else begin
                        action_next      = prarq_pkg::ACT_DROPPED;
                        seq_next         = outstanding;
                        next_seq_next    = ~next_seq_reg;
                        hist_cmd.record  = 1'b1;
                        hist_cmd.outcome = 1'b0;
                        awaiting_next    = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        // Retransmission counts a retry and may hit the limit
        if (retransmit) begin
            action_next = prarq_pkg::ACT_RETRANSMIT;
            seq_next    = outstanding;
            retry_next  = retry_inc;
            if (retry_inc >= max_retries_reg) begin
                gave_next     = 1'b1;
                awaiting_next = 1'b0;
            end
        end
        // History changes only when the event is actually processed
        if (!move) begin
            hist_cmd = '0;
        end
    end

    // History counts reported modulo 2^10
    assign fill_ext = {{CW{1'b0}}, hist_fill_next};
    assign succ_ext = {{CW{1'b0}}, hist_succ_next};

    prarq_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (hist_cmd),
        .target    (target_reg),
        .resend_ok (hist_resend_ok),
        .fill_next (hist_fill_next),
        .succ_next (hist_succ_next)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            next_seq_reg    <= 1'b0;
            awaiting_reg    <= 1'b0;
            retry_reg       <= '0;
            target_reg      <= prarq_pkg::TARGET_RESET;
            max_retries_reg <= prarq_pkg::MAX_RETRIES_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
                next_seq_reg  <= next_seq_next;
                awaiting_reg  <= awaiting_next;
                retry_reg     <= retry_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == prarq_pkg::CFG_TARGET_RELIABILITY) begin
                    target_reg <= cfg_data;
                end else if (cfg_index == prarq_pkg::CFG_MAX_RETRIES) begin
                    max_retries_reg <= cfg_data[prarq_pkg::RETRY_W-1:0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg <= s_tuser;
            in_ack_reg <= s_tdata[0];
            in_syn_reg <= s_tdata[1];
            in_num_reg <= s_tdata[2];
        end
        if (move) begin
            out_action_reg  <= action_next;
            out_seq_reg     <= seq_next;
            out_gave_reg    <= gave_next;
            out_retries_reg <= retry_next;
            out_succ_reg    <= succ_ext[CW-1:0];
            out_fill_reg    <= fill_ext[CW-1:0];
        end
    end

    // A processed send always leaves the sender waiting for an acknowledgement.
    assert property (@(posedge aclk) disable iff (!aresetn)
        move && (in_cmd_reg == prarq_pkg::CMD_SEND) |=> awaiting_reg)
        else $error("send did not start waiting for an acknowledgement");

    // Giving up returns the sender to idle and reports a retransmission.
    assert property (@(posedge aclk) disable iff (!aresetn)
        move && gave_next |=> !awaiting_reg && out_valid_reg
            && (out_action_reg == prarq_pkg::ACT_RETRANSMIT))
        else $error("give-up did not return the sender to idle");

    // An event taken from the input register always lands in the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        move |=> out_valid_reg && (out_retries_reg == retry_reg))
        else $error("processed event lost or retry count mismatch");

endmodule

`default_nettype wire
